@@ rtl/hmr_pkg.sv @@
// Shared types and constants of the HID message reassembler.
package hmr_pkg;

    localparam int REPORT_BYTES_DEFAULT = 64;

    localparam logic [7:0] INIT_FLAG_MASK = 8'h80;
    localparam logic [7:0] COMMAND_MASK   = 8'h7F;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic ERR_WRONG_TYPE   = 1'b0;
    localparam logic ERR_SEQ_MISMATCH = 1'b1;

    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_INIT   = 4'b0010,
        MODE_CONT   = 4'b0100,
        MODE_SKIP   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last_of_message;
        logic [31:0] report_id;
        logic [6:0]  command;
        logic [15:0] message_length;
        logic [15:0] byte_offset;
        logic        error_code;
    } t_result;

endpackage

@@ rtl/hmr_if.sv @@
// Word channels of the HID message reassembler: report bytes in, results out.
interface hmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;

    modport source (output valid, output report_byte, input ready);
    modport sink (input valid, input report_byte, output ready);
endinterface

interface hmr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_of_message;
    logic [31:0] report_id;
    logic [6:0]  command;
    logic [15:0] message_length;
    logic [15:0] byte_offset;
    logic        error_code;

    modport source (output valid, output kind, output data_byte, output last_of_message,
                    output report_id, output command, output message_length,
                    output byte_offset, output error_code, input ready);
    modport sink (input valid, input kind, input data_byte, input last_of_message,
                  input report_id, input command, input message_length,
                  input byte_offset, input error_code, output ready);
endinterface

@@ rtl/hid_message_reassembler_core.sv @@
// Top level of the HID message reassembler: report bytes in, message words out.
// The block takes one report byte per cycle with no gaps of its own; a byte is judged
// against the channel state while it sits in the input register, and its result, if any,
// is written to the output register when the byte leaves the input register.
// The reassembly logic updates its state once per byte, which sets that rate; a result that
// waits to be taken holds the reassembly logic, and the input stops once the input
// register is full.
module hid_message_reassembler_core
    import hmr_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmr_in_if.sink     i_report,
    hmr_out_if.source  o_result
);

    localparam int POS_W = $clog2(REPORT_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_incoming, n_incoming;
    logic [31:0]      r_owner, n_owner;
    logic [15:0]      r_rcv, n_rcv;
    logic [15:0]      r_total, n_total;
    logic [6:0]       r_cmd, n_cmd;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_len_high, n_len_high;
    t_mode            r_mode, n_mode;

    logic             r_out_valid;
    t_result          r_res, n_res;
    logic             n_has_res;

    logic             out_free;
    logic             fire;
    logic [31:0]      full_id;

    assign out_free       = !r_out_valid || o_result.ready;
    assign fire           = r_in_valid && out_free;
    assign i_report.ready = !r_in_valid || out_free;
    assign full_id        = {r_in_byte, r_incoming[23:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_report.ready) begin
            r_in_valid <= i_report.valid;
        end
        if (i_report.valid && i_report.ready) begin
            r_in_byte <= i_report.report_byte;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_incoming = r_incoming;
        n_owner    = r_owner;
        n_rcv      = r_rcv;
        n_total    = r_total;
        n_cmd      = r_cmd;
        n_seq      = r_seq;
        n_len_high = r_len_high;
        n_mode     = r_mode;
        n_res      = '0;
        n_has_res  = 1'b0;

        unique case (r_mode)
            MODE_HEADER: begin
                if (r_pos < POS_W'(4)) begin
                    unique case (r_pos[1:0])
                        2'd0: n_incoming = {24'd0, r_in_byte};
                        2'd1: n_incoming = {r_incoming[31:16], r_in_byte, r_incoming[7:0]};
                        2'd2: n_incoming = {r_incoming[31:24], r_in_byte, r_incoming[15:0]};
                        default: begin
                            n_incoming = full_id;
                            if (full_id == 32'd0) begin
                                n_mode = MODE_SKIP;
                            end else if (full_id != r_owner) begin
                                n_owner    = full_id;
                                n_rcv      = '0;
                                n_total    = '0;
                                n_cmd      = '0;
                                n_seq      = '0;
                                n_len_high = '0;
                            end
                        end
                    endcase
                end else if (r_rcv == 16'd0) begin
                    if ((r_in_byte & INIT_FLAG_MASK) != 8'd0) begin
                        n_cmd  = 7'(r_in_byte & COMMAND_MASK);
                        n_seq  = '0;
                        n_mode = MODE_INIT;
                    end else begin
                        n_has_res            = 1'b1;
                        n_res.kind           = KIND_ERROR;
                        n_res.report_id      = r_incoming;
                        n_res.error_code     = ERR_WRONG_TYPE;
                        n_mode               = MODE_SKIP;
                    end
                end else begin
                    if ((r_in_byte & INIT_FLAG_MASK) != 8'd0) begin
                        n_has_res        = 1'b1;
                        n_res.kind       = KIND_ERROR;
                        n_res.report_id  = r_incoming;
                        n_res.error_code = ERR_WRONG_TYPE;
                        n_mode           = MODE_SKIP;
                    end else if (r_in_byte != r_seq) begin
                        n_has_res        = 1'b1;
                        n_res.kind       = KIND_ERROR;
                        n_res.report_id  = r_incoming;
                        n_res.error_code = ERR_SEQ_MISMATCH;
                        n_mode           = MODE_SKIP;
                    end else begin
                        n_seq  = r_seq + 8'd1;
                        n_mode = MODE_CONT;
                    end
                end
            end
            MODE_INIT, MODE_CONT: begin
                if (r_mode == MODE_INIT && r_pos == POS_W'(5)) begin
                    n_len_high = r_in_byte;
                end else if (r_mode == MODE_INIT && r_pos == POS_W'(6)) begin
                    n_total = {r_len_high, r_in_byte};
                    if ({r_len_high, r_in_byte} == 16'd0) begin
                        n_has_res             = 1'b1;
                        n_res.kind            = KIND_EMPTY;
                        n_res.last_of_message = 1'b1;
                        n_res.report_id       = r_incoming;
                        n_res.command         = r_cmd;
                        n_mode                = MODE_SKIP;
                    end
                end else if (r_mode == MODE_CONT || r_pos > POS_W'(6)) begin
                    if (r_rcv >= r_total) begin
                        n_mode = MODE_SKIP;
                    end else begin
                        n_has_res             = 1'b1;
                        n_res.kind            = KIND_PAYLOAD;
                        n_res.data_byte       = r_in_byte;
                        n_res.last_of_message = (r_rcv + 16'd1) == r_total;
                        n_res.report_id       = r_incoming;
                        n_res.command         = r_cmd;
                        n_res.message_length  = r_total;
                        n_res.byte_offset     = r_rcv;
                        if ((r_rcv + 16'd1) == r_total) begin
                            n_rcv  = '0;
                            n_mode = MODE_SKIP;
                        end else begin
                            n_rcv = r_rcv + 16'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (r_pos == POS_LAST) begin
            n_pos  = '0;
            n_mode = MODE_HEADER;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_incoming <= '0;
            r_owner    <= '0;
            r_rcv      <= '0;
            r_total    <= '0;
            r_cmd      <= '0;
            r_seq      <= '0;
            r_len_high <= '0;
            r_mode     <= MODE_HEADER;
        end else if (fire) begin
            r_pos      <= n_pos;
            r_incoming <= n_incoming;
            r_owner    <= n_owner;
            r_rcv      <= n_rcv;
            r_total    <= n_total;
            r_cmd      <= n_cmd;
            r_seq      <= n_seq;
            r_len_high <= n_len_high;
            r_mode     <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && n_has_res;
        end
        if (fire && n_has_res) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.kind            = r_res.kind;
    assign o_result.data_byte       = r_res.data_byte;
    assign o_result.last_of_message = r_res.last_of_message;
    assign o_result.report_id       = r_res.report_id;
    assign o_result.command         = r_res.command;
    assign o_result.message_length  = r_res.message_length;
    assign o_result.byte_offset     = r_res.byte_offset;
    assign o_result.error_code      = r_res.error_code;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("Report position ran past the end of the report.");

    a_owner_in_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_INIT || r_mode == MODE_CONT) |->
            (r_owner != 32'd0 && r_owner == r_incoming))
        else $error("Message bytes taken for a report that does not own the channel.");

    a_count_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcv == 16'd0 || r_rcv < r_total)
        else $error("Received count reached the declared length without completing.");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_res)))
        else $error("A waiting result was lost or changed.");

endmodule

@@ tb/tb_hid_message_reassembler_core.sv @@
// Testbench of the HID message reassembler: reports are driven, results are predicted and checked.
`timescale 1ns / 1ps

module tb_hid_message_reassembler_core;
    import hmr_pkg::*;

    localparam int RPT          = REPORT_BYTES_DEFAULT;
    localparam int INIT_PAYLOAD = RPT - 7;
    localparam int CONT_PAYLOAD = RPT - 5;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_BYTES = 256;

    typedef struct {
        logic [7:0] b;
        bit         hold;
    } t_feed;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hmr_in_if  report_ch ();
    hmr_out_if result_ch ();

    hid_message_reassembler_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_report (report_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    t_feed      report_feed[$];
    t_result    pending_results[$];
    logic [7:0] rpt [RPT];

    logic [5:0]  rpt_pos  = '0;
    logic [31:0] id_accum = '0;
    logic [31:0] owner    = '0;
    logic [15:0] rx_count = '0;
    logic [15:0] msg_len  = '0;
    logic [6:0]  msg_cmd  = '0;
    logic [7:0]  next_seq = '0;
    logic [7:0]  len_hi   = '0;
    t_mode       pmode    = MODE_HEADER;

    int  fails = 0;
    int  bytes_in = 0;
    int  n_payload = 0;
    int  n_empty = 0;
    int  n_error = 0;
    int  cyc = 0;
    int  stall_cyc = 0;
    bit  in_accepted = 1'b0;

    function automatic void flag_error(input logic code, output t_result r);
        r = '0;
        r.kind = KIND_ERROR;
        r.report_id = id_accum;
        r.error_code = code;
        pmode = MODE_SKIP;
    endfunction

    function automatic bit take_payload(input logic [7:0] b, output t_result r);
        bit last;
        r = '0;
        if (rx_count >= msg_len) begin
            pmode = MODE_SKIP;
            return 1'b0;
        end
        last = (rx_count + 16'd1) == msg_len;
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        r.last_of_message = last;
        r.report_id = id_accum;
        r.command = msg_cmd;
        r.message_length = msg_len;
        r.byte_offset = rx_count;
        if (last) begin
            rx_count = '0;
            pmode = MODE_SKIP;
        end else begin
            rx_count = rx_count + 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic bit reassemble_byte(input logic [7:0] b, output t_result r);
        bit got;
        got = 1'b0;
        r = '0;
        case (pmode)
            MODE_HEADER: begin
                if (rpt_pos < 4) begin
                    if (rpt_pos == 0) id_accum = {24'd0, b};
                    else id_accum = id_accum | (32'(b) << (8 * rpt_pos));
                    if (rpt_pos == 3) begin
                        if (id_accum == '0) begin
                            pmode = MODE_SKIP;
                        end else if (id_accum != owner) begin
                            owner = id_accum;
                            rx_count = '0;
                            msg_len = '0;
                            msg_cmd = '0;
                            next_seq = '0;
                            len_hi = '0;
                        end
                    end
                end else if (rx_count == '0) begin
                    if ((b & INIT_FLAG_MASK) != '0) begin
                        msg_cmd = 7'(b & COMMAND_MASK);
                        next_seq = '0;
                        pmode = MODE_INIT;
                    end else begin
                        flag_error(ERR_WRONG_TYPE, r);
                        got = 1'b1;
                    end
                end else if ((b & INIT_FLAG_MASK) != '0) begin
                    flag_error(ERR_WRONG_TYPE, r);
                    got = 1'b1;
                end else if (b != next_seq) begin
                    flag_error(ERR_SEQ_MISMATCH, r);
                    got = 1'b1;
                end else begin
                    next_seq = next_seq + 8'd1;
                    pmode = MODE_CONT;
                end
            end
            MODE_INIT: begin
                if (rpt_pos == 5) begin
                    len_hi = b;
                end else if (rpt_pos == 6) begin
                    msg_len = {len_hi, b};
                    if (msg_len == '0) begin
                        r.kind = KIND_EMPTY;
                        r.last_of_message = 1'b1;
                        r.report_id = id_accum;
                        r.command = msg_cmd;
                        pmode = MODE_SKIP;
                        got = 1'b1;
                    end
                end else if (rpt_pos > 6) begin
                    got = take_payload(b, r);
                end
            end
            MODE_CONT: got = take_payload(b, r);
            default: ;
        endcase
        if (rpt_pos == 6'(RPT - 1)) begin
            rpt_pos = '0;
            pmode = MODE_HEADER;
        end else begin
            rpt_pos = rpt_pos + 6'd1;
        end
        return got;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    task automatic fill_report(input logic [31:0] id, input logic [7:0] head);
        foreach (rpt[k]) rpt[k] = 8'($urandom);
        for (int k = 0; k < 4; k++) rpt[k] = id[8*k +: 8];
        rpt[4] = head;
    endtask

    task automatic queue_report(input bit hold);
        foreach (rpt[k]) report_feed.push_back('{b: rpt[k], hold: hold && (k == 0)});
    endtask

    function automatic int conts_for(input logic [15:0] len);
        if (int'(len) <= INIT_PAYLOAD) return 0;
        return (int'(len) - INIT_PAYLOAD + CONT_PAYLOAD - 1) / CONT_PAYLOAD;
    endfunction

    task automatic send_message(input logic [31:0] id, input logic [6:0] cmd,
                                input logic [15:0] len, input int n_cont, input bit hold);
        fill_report(id, INIT_FLAG_MASK | {1'b0, cmd});
        rpt[5] = len[15:8];
        rpt[6] = len[7:0];
        queue_report(hold);
        for (int s = 0; s < n_cont; s++) begin
            fill_report(id, 8'(s));
            queue_report(1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result r;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= report_ch.valid && report_ch.ready;
            if (result_ch.valid && result_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation waiting: kind %0d", result_ch.kind);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(result_ch.kind));
                    check_field("data_byte", 32'(want.data_byte), 32'(result_ch.data_byte));
                    check_field("last_of_message", 32'(want.last_of_message),
                                32'(result_ch.last_of_message));
                    check_field("report_id", want.report_id, result_ch.report_id);
                    check_field("command", 32'(want.command), 32'(result_ch.command));
                    check_field("message_length", 32'(want.message_length),
                                32'(result_ch.message_length));
                    check_field("byte_offset", 32'(want.byte_offset),
                                32'(result_ch.byte_offset));
                    check_field("error_code", 32'(want.error_code), 32'(result_ch.error_code));
                    case (want.kind)
                        KIND_PAYLOAD: n_payload++;
                        KIND_EMPTY:   n_empty++;
                        default:      n_error++;
                    endcase
                end
            end
            if (report_ch.valid && report_ch.ready) begin
                bytes_in++;
                if (reassemble_byte(report_ch.report_byte, r)) pending_results.push_back(r);
            end
        end
    end

    always @(negedge i_clk) begin
        logic       nv;
        logic [7:0] nb;
        bit         steady;
        if (!i_rst_n) begin
            report_ch.valid <= 1'b0;
            result_ch.ready <= 1'b0;
        end else begin
            steady = (cyc >= 400) && (cyc < 900);
            nv = report_ch.valid;
            nb = report_ch.report_byte;
            if (!report_ch.valid || in_accepted) begin
                nv = 1'b0;
                if (report_feed.size() > 0 && (steady || $urandom_range(99) >= 33)
                    && !(report_feed[0].hold && pending_results.size() != 0)) begin
                    nv = 1'b1;
                    nb = report_feed[0].b;
                    void'(report_feed.pop_front());
                end
            end
            report_ch.valid <= nv;
            report_ch.report_byte <= nb;
            result_ch.ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((report_ch.valid && report_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                stall_cyc <= 0;
            end else if (stall_cyc >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                stall_cyc <= stall_cyc + 1;
            end
        end
    end

    initial begin
        logic [31:0] pool [3];
        logic [31:0] id;
        logic [15:0] len;
        int          base;
        int          pick;
        bit          first;

        // Directed part: an empty message, errors, an ignored report and channel changes.
        send_message(32'hFFFF_FFFF, 7'h7F, 16'd0, 0, 1'b0);
        fill_report(32'hFFFF_FFFF, 8'h00);
        queue_report(1'b0);
        send_message(32'h0000_0001, 7'h41, 16'd200, 1, 1'b0);
        fill_report(32'h0000_0001, 8'h05);
        queue_report(1'b0);
        fill_report(32'h0000_0001, 8'hC1);
        queue_report(1'b0);
        fill_report(32'h0, 8'h01);
        queue_report(1'b0);
        fill_report(32'h0000_0001, 8'h01);
        queue_report(1'b0);
        fill_report(32'h0000_0001, 8'h02);
        queue_report(1'b0);
        send_message(32'h1234_5678, 7'h23, 16'(INIT_PAYLOAD + 1), 1, 1'b1);
        fill_report(32'h0000_0001, 8'h02);
        queue_report(1'b0);

        pool = '{32'h0000_0A01, 32'h8000_0000, 32'h00FF_00FF};
        base = report_feed.size();
        first = 1'b1;
        while (report_feed.size() < base + RANDOM_BYTES) begin
            pick = $urandom_range(99);
            id = pool[$urandom_range(2)];
            if ($urandom_range(9) == 0) id = $urandom;
            len = ($urandom_range(9) < 8) ? 16'($urandom_range(120))
                                          : 16'($urandom_range(121, 300));
            if (pick < 72) begin
                send_message(id, 7'($urandom), len, conts_for(len),
                             first || $urandom_range(5) == 0);
                first = 1'b0;
            end else if (pick < 82) begin
                send_message(id, 7'($urandom), len,
                             conts_for(len) + int'($urandom_range(2)) - 1, 1'b0);
            end else if (pick < 88) begin
                fill_report(id, 8'($urandom));
                queue_report(1'b0);
            end else if (pick < 94) begin
                fill_report(id, 8'($urandom_range(3)));
                queue_report(1'b0);
            end else begin
                fill_report(32'h0, 8'($urandom));
                queue_report(1'b0);
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (report_feed.size() != 0 || report_ch.valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d report bytes; checked %0d payload, %0d empty and %0d error words.",
                 bytes_in, n_payload, n_empty, n_error);
        $display("Reports covered channel changes, ignored id-zero reports, empty and padded");
        $display("messages, wrong report types and sequence mismatches, with stalls on both sides.");
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
